// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- rtl/core/ntt3_pkg.sv -----
// ----------------------------------------------------------------------------
// Neighbor table package
// Types and constants shared by the neighbor table, its channels and units.
// ----------------------------------------------------------------------------
package ntt3_pkg;

   localparam int ADDR_W = 16;
   localparam int STR_W  = 9;

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic signed [STR_W-1:0]  str_type;

   typedef enum logic [1:0] {
      ST_UPDATED = 2'd0,
      ST_ADDED   = 2'd1,
      ST_FULL    = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_APPEND,
      FSM_DONE
   } fsm_type;

   // one table slot as stored in the RAM
   typedef struct packed {
      addr_type addr;
      str_type  str;
   } slot_type;

   // one rank of the running top three
   typedef struct packed {
      logic     valid;
      addr_type addr;
      str_type  str;
   } rank_entry_type;

   // sequencer commands to the ranking unit
   typedef struct packed {
      logic     clear;
      logic     insert;
      addr_type addr;
      str_type  str;
   } rank_ctl_type;

endpackage

// ----- rtl/core/ntt3_intf.sv -----
// ----------------------------------------------------------------------------
// Neighbor table channels
// Valid/ready channels for observation words and result words.
// ----------------------------------------------------------------------------
interface ntt3_req_if;
   import ntt3_pkg::*;

   logic     valid;
   logic     ready;
   addr_type node_address;
   str_type  signal_strength;

   modport source (output valid, node_address, signal_strength, input ready);
   modport sink   (input valid, node_address, signal_strength, output ready);
endinterface

interface ntt3_rsp_if;
   import ntt3_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   addr_type   first_address;
   str_type    first_strength;
   addr_type   second_address;
   str_type    second_strength;
   addr_type   third_address;
   str_type    third_strength;

   modport source (output valid, status, first_address, first_strength,
                   second_address, second_strength, third_address, third_strength,
                   input ready);
   modport sink   (input valid, status, first_address, first_strength,
                   second_address, second_strength, third_address, third_strength,
                   output ready);
endinterface

// ----- rtl/core/ntt3_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ntt3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ntt3_rank.sv -----
// ----------------------------------------------------------------------------
// Neighbor table ranking unit
// Keeps the three strongest entries seen since the last clear, one insert
// a cycle; a tie keeps the entry inserted first.
// ----------------------------------------------------------------------------
module ntt3_rank (
   input  logic                    clock,
   input  logic                    reset,
   input  ntt3_pkg::rank_ctl_type  ctl,
   output ntt3_pkg::rank_entry_type first,
   output ntt3_pkg::rank_entry_type second,
   output ntt3_pkg::rank_entry_type third
);
   import ntt3_pkg::*;

   rank_entry_type e1_ff, e2_ff, e3_ff;
   rank_entry_type e1_in, e2_in, e3_in;
   rank_entry_type cand;

   always_comb begin
      cand.valid = 1'b1;
      cand.addr  = ctl.addr;
      cand.str   = ctl.str;
      e1_in = e1_ff;
      e2_in = e2_ff;
      e3_in = e3_ff;
      if (ctl.clear) begin
         e1_in.valid = 1'b0;
         e2_in.valid = 1'b0;
         e3_in.valid = 1'b0;
      end else if (ctl.insert) begin
         if (!e1_ff.valid || (ctl.str > e1_ff.str)) begin
            e3_in = e2_ff;
            e2_in = e1_ff;
            e1_in = cand;
         end else if (!e2_ff.valid || (ctl.str > e2_ff.str)) begin
            e3_in = e2_ff;
            e2_in = cand;
         end else if (!e3_ff.valid || (ctl.str > e3_ff.str)) begin
            e3_in = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff.valid <= 1'b0;
         e2_ff.valid <= 1'b0;
         e3_ff.valid <= 1'b0;
      end else begin
         e1_ff.valid <= e1_in.valid;
         e2_ff.valid <= e2_in.valid;
         e3_ff.valid <= e3_in.valid;
      end
      e1_ff.addr <= e1_in.addr;
      e1_ff.str  <= e1_in.str;
      e2_ff.addr <= e2_in.addr;
      e2_ff.str  <= e2_in.str;
      e3_ff.addr <= e3_in.addr;
      e3_ff.str  <= e3_in.str;
   end

   assign first  = e1_ff;
   assign second = e2_ff;
   assign third  = e3_ff;

endmodule

// ----- rtl/core/neighbor_table_top3_rssi.sv -----
// ----------------------------------------------------------------------------
// Neighbor table, top three by RSSI
// Looks up or adds each observed neighbor and reports the three strongest.
// ----------------------------------------------------------------------------
//   channel   dir   handshake     word
//   req_port  in    valid/ready   node_address, signal_strength
//   rsp_port  out   valid/ready   status, first/second/third address+strength
//
// An observation walks fill slots, at most TABLE_DEPTH, where fill is the number
// of occupied slots, then passes through append and done: the walk reads one
// slot a cycle through the single read port of the slot RAM and feeds the
// ranking unit.
// Reset empties the table at once through the fill count; no RAM sweep.
// req_port.ready is high only while idle; a held result stalls the block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module neighbor_table_top3_rssi #(
   parameter int TABLE_DEPTH = 20
) (
   input logic        clock,
   input logic        reset,
   ntt3_req_if.sink   req_port,
   ntt3_rsp_if.source rsp_port
);
   import ntt3_pkg::*;

   localparam int IDXW = $clog2(TABLE_DEPTH);
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);

   fsm_type          state_ff, state_in;
   addr_type         obs_addr_ff, obs_addr_in;
   str_type          obs_str_ff, obs_str_in;
   logic [CNTW-1:0]  iss_ff, iss_in;
   logic [CNTW-1:0]  fill_ff, fill_in;
   logic             vld_ff, vld_in;
   logic [IDXW-1:0]  cur_idx_ff, cur_idx_in;
   logic             found_ff, found_in;
   status_type       status_ff, status_in;

   logic             rd_en;
   logic             wr_en;
   logic [IDXW-1:0]  wr_addr;
   slot_type         wr_slot;
   slot_type         rd_slot;
   logic             issue;
   logic             match;
   rank_ctl_type     rank_ctl;
   rank_entry_type   r1, r2, r3;

   ntt3_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[IDXW-1:0]),
      .rd_data (rd_slot)
   );

   ntt3_rank u_rank (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rank_ctl),
      .first  (r1),
      .second (r2),
      .third  (r3)
   );

   assign issue = (iss_ff < fill_ff);
   assign match = (obs_addr_ff != '0) && (rd_slot.addr == obs_addr_ff);

   always_comb begin
      state_in    = state_ff;
      obs_addr_in = obs_addr_ff;
      obs_str_in  = obs_str_ff;
      iss_in      = iss_ff;
      fill_in     = fill_ff;
      vld_in      = 1'b0;
      cur_idx_in  = cur_idx_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cur_idx_ff;
      wr_slot     = rd_slot;
      rank_ctl    = '0;
      req_port.ready = 1'b0;
      rsp_port.valid = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               obs_addr_in    = req_port.node_address;
               obs_str_in     = req_port.signal_strength;
               iss_in         = '0;
               found_in       = 1'b0;
               rank_ctl.clear = 1'b1;
               state_in       = FSM_WALK;
            end
         end
         FSM_WALK: begin
            // issue slot iss_ff, score the slot issued the cycle before
            if (issue) begin
               rd_en      = 1'b1;
               iss_in     = iss_ff + CNTW'(1);
               vld_in     = 1'b1;
               cur_idx_in = iss_ff[IDXW-1:0];
            end
            if (vld_ff) begin
               rank_ctl.insert = 1'b1;
               rank_ctl.addr   = rd_slot.addr;
               rank_ctl.str    = match ? obs_str_ff : rd_slot.str;
               if (match) begin
                  wr_en       = 1'b1;
                  wr_slot.str = obs_str_ff;
                  found_in    = 1'b1;
               end
            end
            if (!issue && !vld_ff) begin
               state_in = FSM_APPEND;
            end
         end
         FSM_APPEND: begin
            state_in = FSM_DONE;
            if (obs_addr_ff == '0) begin
               status_in = ST_IGNORED;
            end else if (found_ff) begin
               status_in = ST_UPDATED;
            end else if (fill_ff < CNTW'(TABLE_DEPTH)) begin
               // new neighbor goes in the first free slot, ranked last on ties
               wr_en           = 1'b1;
               wr_addr         = fill_ff[IDXW-1:0];
               wr_slot.addr    = obs_addr_ff;
               wr_slot.str     = obs_str_ff;
               fill_in         = fill_ff + CNTW'(1);
               rank_ctl.insert = 1'b1;
               rank_ctl.addr   = obs_addr_ff;
               rank_ctl.str    = obs_str_ff;
               status_in       = ST_ADDED;
            end else begin
               status_in = ST_FULL;
            end
         end
         FSM_DONE: begin
            rsp_port.valid = 1'b1;
            if (rsp_port.ready) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         fill_ff  <= '0;
         vld_ff   <= 1'b0;
         iss_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         vld_ff   <= vld_in;
         iss_ff   <= iss_in;
         found_ff <= found_in;
      end
      obs_addr_ff <= obs_addr_in;
      obs_str_ff  <= obs_str_in;
      cur_idx_ff  <= cur_idx_in;
      status_ff   <= status_in;
   end

   assign rsp_port.status          = status_ff;
   assign rsp_port.first_address   = r1.valid ? r1.addr : '0;
   assign rsp_port.first_strength  = r1.valid ? r1.str  : '0;
   assign rsp_port.second_address  = r2.valid ? r2.addr : '0;
   assign rsp_port.second_strength = r2.valid ? r2.str  : '0;
   assign rsp_port.third_address   = r3.valid ? r3.addr : '0;
   assign rsp_port.third_strength  = r3.valid ? r3.str  : '0;

   `ASSERT_CLK(a_fill_bound, fill_ff <= CNTW'(TABLE_DEPTH), "fill count beyond table depth")
   `ASSERT_CLK(a_fill_on_add, (fill_ff != $past(fill_ff)) |-> (rsp_port.valid && (status_ff == ST_ADDED)), "fill count moved without an add")
   `ASSERT_CLK(a_rank_order, (r2.valid && rsp_port.valid) |-> (r1.valid && (r1.str >= r2.str)), "ranks one and two out of order")
   `ASSERT_NEVER(a_busy_ready, req_port.ready && rsp_port.valid, "ready while a result is pending")

endmodule
